// ===== sv/pdr_pkg.sv =====
`timescale 1ns / 1ps
// pdr_pkg: types, constants and the arctangent table for planar dead reckoning
// no dependencies; imported by planar_dead_reckoning_top
package pdr_pkg;

  // request on the input channel
  typedef struct packed {
    logic [31:0]        stamp_sec;
    logic [29:0]        stamp_nsec;
    logic signed [23:0] speed;
    logic signed [23:0] yaw_rate;
  } pdr_in_t;

  // request on the output channel
  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [31:0] heading;
    logic [31:0]        out_sec;
    logic [29:0]        out_nsec;
  } pdr_out_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_TIME,
    ST_CUR,
    ST_DIFF,
    ST_CLAMP,
    ST_YAW_M,
    ST_YAW_LO,
    ST_YAW_HI,
    ST_YAW_ADD,
    ST_DIST_M,
    ST_DIV_INIT,
    ST_RECIP,
    ST_QEST,
    ST_REM,
    ST_QFIX,
    ST_ROT,
    ST_ROT_FIX,
    ST_MUL_X,
    ST_RND_X,
    ST_ACC_X,
    ST_ACC_Y,
    ST_DONE
  } pdr_state_e;

  // register index, taken from paddr[2]
  localparam logic CFG_MAX_STEP = 1'b0;

  localparam logic [31:0] MAX_STEP_RESET = 32'd1000000000;
  localparam logic [31:0] NS_PER_S       = 32'd1000000000;
  localparam logic [31:0] YAW_SCALE      = 32'd2935890503;

  // distance over one second by reciprocal multiply, estimate low by at most two
  localparam int          QUOT_W   = 27;
  localparam logic [55:0] NS_HALF  = 56'd500000000;
  localparam logic [31:0] RECIP_NS = 32'd72057594;   // floor(2^56 / 10^9)
  localparam logic [31:0] NS_TWO_S = 32'd2000000000;

  // cordic datapath
  localparam int                 ROT_W       = 34;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [33:0] QUARTER     = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN   = 34'sd2147483648;

  localparam logic signed [47:0] POS_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] POS_MIN = 48'sh8000_0000_0000;

  // round(atan(2^-i) * 2^31 / pi)
  function automatic logic [29:0] pdr_atan(input logic [4:0] idx);
    logic [29:0] v;
    case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== sv/planar_dead_reckoning_top.sv =====
`timescale 1ns / 1ps
// planar_dead_reckoning_top: 2-d odometry integrator with a shared multiplier,
// a reciprocal divide and an iterative cordic; depends on pdr_pkg
//
//   channel   direction  handshake               payload
//   in        sink       in_valid_i / in_stall_o  in_data_i  (pdr_in_t)
//   out       source     out_valid_o / out_stall_i out_data_o (pdr_out_t)
//   config    apb slave  psel penable pwrite pready paddr pwdata prdata
//
// one request runs from acceptance to the result register through the sequencer
// states, and the next request can be taken in the cycle after; the cordic loop
// runs one rotation a cycle, and every product, including the divide by 10^9 as a
// reciprocal multiply, goes through one 32x32 multiplier. in_stall_o stays high
// until the sequencer is back in idle.
// the result sits in an output register, so a new request is taken while the
// previous result is still stalled; a second result waits in the last state.
// reset (rst_ni low, async) clears position and heading, sets the first-sample
// flag and sets max_step_ns to one second.
module planar_dead_reckoning_top import pdr_pkg::*; #(
  parameter int CORDIC_STEPS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input requests
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  pdr_in_t     in_data_i,
  // result requests
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output pdr_out_t    out_data_o,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IterW = $clog2(CORDIC_STEPS);
  localparam logic [IterW-1:0] RotLast = IterW'(CORDIC_STEPS - 1);

  pdr_state_e state_q, state_d;

  // control and architectural state
  logic [31:0]        max_step_q;
  logic               first_q;
  logic [62:0]        prev_ns_q;
  logic [31:0]        yaw_q;
  logic signed [47:0] x_acc_q, y_acc_q;
  logic               out_valid_q;

  // working registers
  pdr_in_t            item_q;
  pdr_out_t           out_q;
  logic [63:0]        p_q;
  logic [62:0]        cur_q;
  logic [62:0]        dmag_full_q;
  logic               dneg_q;
  logic [31:0]        dmag_q;
  logic [23:0]        mhi_q;
  logic [31:0]        tmp_q;
  logic [55:0]        num_q;
  logic [31:0]        rem_q;
  logic [QUOT_W-1:0]  quot_q;
  logic signed [ROT_W-1:0] x_q, y_q, z_q;
  logic               fold_neg_q;
  logic [IterW-1:0]   rot_cnt_q;
  logic [31:0]        cmag_q, smag_q;
  logic               cneg_q, sneg_q;
  logic signed [28:0] step_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic        accept;
  logic        out_free;
  logic        cfg_wr;
  logic [23:0] rate_mag, speed_mag;
  logic        yaw_neg, dist_neg;

  // time difference
  logic [62:0] prv_ns;
  logic [63:0] diff_fw;
  logic [63:0] hi_sum;
  logic [31:0] dyaw;

  // remainder of the quotient estimate, below three seconds
  logic [55:0] rem_full;

  // cordic step
  logic signed [ROT_W-1:0] zs, xs, ys, atan_v;
  logic signed [ROT_W-1:0] x_abs, y_abs;

  function automatic logic signed [28:0] round_q30(input logic [63:0] p, input logic neg);
    logic [63:0]        r;
    logic signed [28:0] m;
    r = p + 64'h2000_0000;
    m = {1'b0, r[57:30]};
    return neg ? -m : m;
  endfunction

  function automatic logic signed [47:0] sat_add(input logic signed [47:0] acc,
                                                 input logic signed [28:0] st);
    logic signed [48:0] sum;
    sum = {acc[47], acc} + {{20{st[28]}}, st};
    if (sum[48] != sum[47]) begin
      return sum[48] ? POS_MIN : POS_MAX;
    end
    return sum[47:0];
  endfunction

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // apb: single register at word 0, no wait states
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == CFG_MAX_STEP) ? max_step_q : 32'd0;

  // magnitudes and signs of the sample
  assign rate_mag  = item_q.yaw_rate[23] ? (~item_q.yaw_rate + 24'd1) : item_q.yaw_rate;
  assign speed_mag = item_q.speed[23] ? (~item_q.speed + 24'd1) : item_q.speed;
  assign yaw_neg   = item_q.yaw_rate[23] ^ dneg_q;
  assign dist_neg  = item_q.speed[23] ^ dneg_q;

  // first sample measures against itself, so dt is zero
  assign prv_ns  = first_q ? cur_q : prev_ns_q;
  assign diff_fw = {1'b0, cur_q} - {1'b0, prv_ns};

  // heading step: round(m * scale / 2^48) from two partial products
  assign hi_sum = p_q + {32'd0, tmp_q} + 64'h8000;
  assign dyaw   = hi_sum[47:16];

  assign rem_full = num_q - p_q[55:0];

  // fold heading into [-pi/2, pi/2]
  assign zs     = {{2{yaw_q[31]}}, yaw_q};
  assign xs     = x_q >>> rot_cnt_q;
  assign ys     = y_q >>> rot_cnt_q;
  assign atan_v = {4'd0, pdr_atan(5'(rot_cnt_q))};
  assign x_abs  = x_q[ROT_W-1] ? -x_q : x_q;
  assign y_abs  = y_q[ROT_W-1] ? -y_q : y_q;

  // multiplier operand select
  always_comb begin
    mul_a = 32'd0;
    mul_b = 32'd0;
    unique case (state_q)
      ST_TIME: begin
        mul_a = item_q.stamp_sec;
        mul_b = NS_PER_S;
      end
      ST_YAW_M: begin
        mul_a = {8'd0, rate_mag};
        mul_b = dmag_q;
      end
      ST_YAW_LO: begin
        mul_a = p_q[31:0];
        mul_b = YAW_SCALE;
      end
      ST_YAW_HI: begin
        mul_a = {8'd0, mhi_q};
        mul_b = YAW_SCALE;
      end
      ST_DIST_M: begin
        mul_a = {8'd0, speed_mag};
        mul_b = dmag_q;
      end
      // quotient estimate from the top 32 bits of the rounded distance
      ST_RECIP: begin
        mul_a = num_q[55:24];
        mul_b = RECIP_NS;
      end
      // estimate back to nanosecond units for the remainder
      ST_QEST: begin
        mul_a = {5'd0, p_q[58:32]};
        mul_b = NS_PER_S;
      end
      ST_MUL_X: begin
        mul_a = 32'(quot_q);
        mul_b = cmag_q;
      end
      ST_RND_X: begin
        mul_a = 32'(quot_q);
        mul_b = smag_q;
      end
      default: ;
    endcase
  end

  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (accept) state_d = ST_TIME;
      ST_TIME:     state_d = ST_CUR;
      ST_CUR:      state_d = ST_DIFF;
      ST_DIFF:     state_d = ST_CLAMP;
      ST_CLAMP:    state_d = ST_YAW_M;
      ST_YAW_M:    state_d = ST_YAW_LO;
      ST_YAW_LO:   state_d = ST_YAW_HI;
      ST_YAW_HI:   state_d = ST_YAW_ADD;
      ST_YAW_ADD:  state_d = ST_DIST_M;
      ST_DIST_M:   state_d = ST_DIV_INIT;
      ST_DIV_INIT: state_d = ST_RECIP;
      ST_RECIP:    state_d = ST_QEST;
      ST_QEST:     state_d = ST_REM;
      ST_REM:      state_d = ST_QFIX;
      ST_QFIX:     state_d = ST_ROT;
      ST_ROT:      if (rot_cnt_q == RotLast) state_d = ST_ROT_FIX;
      ST_ROT_FIX:  state_d = ST_MUL_X;
      ST_MUL_X:    state_d = ST_RND_X;
      ST_RND_X:    state_d = ST_ACC_X;
      ST_ACC_X:    state_d = ST_ACC_Y;
      ST_ACC_Y:    state_d = ST_DONE;
      ST_DONE:     if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  // architectural state and control flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_step_q  <= MAX_STEP_RESET;
      first_q     <= 1'b1;
      prev_ns_q   <= '0;
      yaw_q       <= '0;
      x_acc_q     <= '0;
      y_acc_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == CFG_MAX_STEP) begin
        max_step_q <= pwdata;
      end
      if (state_q == ST_DIFF) begin
        prev_ns_q <= cur_q;
        first_q   <= 1'b0;
      end
      if (state_q == ST_YAW_ADD) begin
        yaw_q <= yaw_neg ? (yaw_q - dyaw) : (yaw_q + dyaw);
      end
      if (state_q == ST_ACC_X) begin
        x_acc_q <= sat_add(x_acc_q, step_q);
      end
      if (state_q == ST_ACC_Y) begin
        y_acc_q <= sat_add(y_acc_q, step_q);
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    unique case (state_q)
      ST_TIME: p_q <= mul_p;
      // absolute time in ns; nsec taken literally even past one second
      ST_CUR:  cur_q <= p_q[62:0] + {33'd0, item_q.stamp_nsec};
      ST_DIFF: begin
        dneg_q      <= diff_fw[63];
        dmag_full_q <= diff_fw[63] ? (prv_ns - cur_q) : diff_fw[62:0];
      end
      ST_CLAMP: begin
        dmag_q <= (dmag_full_q > {31'd0, max_step_q}) ? max_step_q : dmag_full_q[31:0];
      end
      ST_YAW_M: p_q <= mul_p;
      ST_YAW_LO: begin
        mhi_q <= p_q[55:32];
        p_q   <= mul_p;
      end
      ST_YAW_HI: begin
        tmp_q <= p_q[63:32];
        p_q   <= mul_p;
      end
      ST_DIST_M: p_q <= mul_p;
      ST_DIV_INIT: begin
        // distance rounded half up, then divided by 10^9
        num_q     <= p_q[55:0] + NS_HALF;
        x_q       <= CORDIC_GAIN;
        y_q       <= '0;
        rot_cnt_q <= '0;
        if (zs > QUARTER) begin
          z_q        <= zs - HALF_TURN;
          fold_neg_q <= 1'b1;
        end else if (zs < -QUARTER) begin
          z_q        <= zs + HALF_TURN;
          fold_neg_q <= 1'b1;
        end else begin
          z_q        <= zs;
          fold_neg_q <= 1'b0;
        end
      end
      ST_RECIP: p_q <= mul_p;
      ST_QEST: begin
        quot_q <= p_q[58:32];
        p_q    <= mul_p;
      end
      ST_REM: rem_q <= rem_full[31:0];
      // estimate is short by zero, one or two
      ST_QFIX: begin
        if (rem_q >= NS_TWO_S) begin
          quot_q <= quot_q + QUOT_W'(2);
        end else if (rem_q >= NS_PER_S) begin
          quot_q <= quot_q + QUOT_W'(1);
        end
      end
      ST_ROT: begin
        if (!z_q[ROT_W-1]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - atan_v;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + atan_v;
        end
        rot_cnt_q <= rot_cnt_q + 1'b1;
      end
      ST_ROT_FIX: begin
        cneg_q <= fold_neg_q ^ x_q[ROT_W-1];
        sneg_q <= fold_neg_q ^ y_q[ROT_W-1];
        cmag_q <= x_abs[31:0];
        smag_q <= y_abs[31:0];
      end
      ST_MUL_X: p_q <= mul_p;
      ST_RND_X: begin
        step_q <= round_q30(p_q, dist_neg ^ cneg_q);
        p_q    <= mul_p;
      end
      ST_ACC_X: step_q <= round_q30(p_q, dist_neg ^ sneg_q);
      ST_DONE: begin
        if (out_free) begin
          out_q.pos_x    <= x_acc_q;
          out_q.pos_y    <= y_acc_q;
          out_q.heading  <= yaw_q;
          out_q.out_sec  <= item_q.stamp_sec;
          out_q.out_nsec <= item_q.stamp_nsec;
        end
      end
      default: ;
    endcase
  end

endmodule
